// ----- rtl/gpx_pkg.sv -----
// Shared types and register map for the I2C GPIO expander register block.
// No dependencies; used by rtl/i2c_gpio_expander_regs.sv.
`timescale 1ns / 1ps

package gpx_pkg;

   // Byte width of register data and pad vectors on the ports
   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned PadCountDefault = 8;

   typedef logic [ByteWidth-1:0] byte_type;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [ByteWidth-1:0] {
      ADDR_ID       = 8'h01,
      ADDR_DIR      = 8'h03,
      ADDR_OUT      = 8'h05,
      ADDR_HIZ      = 8'h07,
      ADDR_LEVEL    = 8'h09,
      ADDR_PULL_EN  = 8'h0b,
      ADDR_PULL_DIR = 8'h0d,
      ADDR_IN       = 8'h0f,
      ADDR_MASK     = 8'h11,
      ADDR_STATUS   = 8'h13
   } addr_type;

   typedef struct packed {
      logic [1:0] cmd;
      byte_type   reg_addr;
      byte_type   write_data;
      byte_type   pin_levels;
   } req_type;

   typedef struct packed {
      byte_type read_data;
      logic     irq_n;
      byte_type drive_enable;
      byte_type drive_value;
      byte_type pull_up_on;
      byte_type pull_down_on;
   } rsp_type;

endpackage

// ----- rtl/i2c_gpio_expander_regs.sv -----
// Register file and pad logic of an eight-pad I2C GPIO expander.
// Depends on rtl/gpx_pkg.sv (beat types, command and address codes).
`timescale 1ns / 1ps

// Channel | Ports                                 | Beat
// --------+---------------------------------------+-----------------------------------
// request | req_valid, req_ready, req_data        | write, read or pin-sample tick
// result  | rsp_valid, rsp_ready, rsp_data        | read byte, irq_n, pad drive/pulls
//
// One beat per clock sustained while rsp_ready is high. A request beat is registered at
// accept in the input stage; its result is registered in the result register when the
// input stage advances, which waits while an untaken result is held.
// Sync reset clears the register file, sets the reset-done flag, empties both stages.
// With rsp_ready low the result holds, the input stage takes one more beat,
// then req_ready drops until the result is taken.

module i2c_gpio_expander_regs #(
   parameter int unsigned PAD_COUNT = gpx_pkg::PadCountDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gpx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gpx_pkg::rsp_type rsp_data
);

   typedef logic [PAD_COUNT-1:0] pads_type;

   // ------------------------------------------------------------------
   // Input stage
   // ------------------------------------------------------------------
   logic             in_valid_ff;
   logic             in_valid_in;
   gpx_pkg::req_type in_beat_ff;

   logic out_free;   // result register can load this cycle
   logic advance;    // input stage item retires into result register
   logic req_fire;

   assign out_free  = !rsp_valid || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_beat_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------
   pads_type dir_ff,      dir_in;
   pads_type out_ff,      out_in;
   pads_type hiz_ff,      hiz_in;
   pads_type level_ff,    level_in;
   pads_type pull_en_ff,  pull_en_in;
   pads_type pull_up_ff,  pull_up_in;
   pads_type mask_ff,     mask_in;
   pads_type status_ff,   status_in;
   pads_type sampled_ff,  sampled_in;
   logic     reset_done_ff, reset_done_in;

   gpx_pkg::byte_type rd_byte;
   pads_type          wr_pads;
   pads_type          pin_pads;

   assign wr_pads  = in_beat_ff.write_data[PAD_COUNT-1:0];
   assign pin_pads = in_beat_ff.pin_levels[PAD_COUNT-1:0];

   always_comb begin
      dir_in        = dir_ff;
      out_in        = out_ff;
      hiz_in        = hiz_ff;
      level_in      = level_ff;
      pull_en_in    = pull_en_ff;
      pull_up_in    = pull_up_ff;
      mask_in       = mask_ff;
      status_in     = status_ff;
      sampled_in    = sampled_ff;
      reset_done_in = reset_done_ff;
      rd_byte       = '0;

      case (in_beat_ff.cmd)
         gpx_pkg::CMD_WRITE: begin
            unique case (in_beat_ff.reg_addr)
               gpx_pkg::ADDR_ID: begin
                  // soft reset on bit 0; flag reads back as ID bit 1
                  if (in_beat_ff.write_data[0]) begin
                     dir_in        = '0;
                     out_in        = '0;
                     hiz_in        = '0;
                     level_in      = '0;
                     pull_en_in    = '0;
                     pull_up_in    = '0;
                     mask_in       = '0;
                     status_in     = '0;
                     sampled_in    = '0;
                     reset_done_in = 1'b1;
                  end
               end
               gpx_pkg::ADDR_DIR:      dir_in     = wr_pads;
               gpx_pkg::ADDR_OUT:      out_in     = wr_pads;
               gpx_pkg::ADDR_HIZ:      hiz_in     = wr_pads;
               gpx_pkg::ADDR_LEVEL:    level_in   = wr_pads;
               gpx_pkg::ADDR_PULL_EN:  pull_en_in = wr_pads;
               gpx_pkg::ADDR_PULL_DIR: pull_up_in = wr_pads;
               gpx_pkg::ADDR_MASK:     mask_in    = wr_pads;
               default: ;  // read-only or unmapped: ignored
            endcase
         end
         gpx_pkg::CMD_READ: begin
            unique case (in_beat_ff.reg_addr)
               gpx_pkg::ADDR_ID:
                  rd_byte = gpx_pkg::byte_type'({reset_done_ff, 1'b0});
               gpx_pkg::ADDR_DIR:      rd_byte = gpx_pkg::byte_type'(dir_ff);
               gpx_pkg::ADDR_OUT:      rd_byte = gpx_pkg::byte_type'(out_ff);
               gpx_pkg::ADDR_HIZ:      rd_byte = gpx_pkg::byte_type'(hiz_ff);
               gpx_pkg::ADDR_LEVEL:    rd_byte = gpx_pkg::byte_type'(level_ff);
               gpx_pkg::ADDR_PULL_EN:  rd_byte = gpx_pkg::byte_type'(pull_en_ff);
               gpx_pkg::ADDR_PULL_DIR: rd_byte = gpx_pkg::byte_type'(pull_up_ff);
               gpx_pkg::ADDR_IN:       rd_byte = gpx_pkg::byte_type'(sampled_ff);
               gpx_pkg::ADDR_MASK:     rd_byte = gpx_pkg::byte_type'(mask_ff);
               gpx_pkg::ADDR_STATUS: begin
                  // clear on read
                  rd_byte   = gpx_pkg::byte_type'(status_ff);
                  status_in = '0;
               end
               default: rd_byte = '0;
            endcase
         end
         gpx_pkg::CMD_TICK: begin
            // sticky mismatch against compare level, masked pads excluded
            sampled_in = pin_pads;
            status_in  = status_ff | ((pin_pads ^ level_ff) & ~mask_ff);
         end
         default: ;  // unused command: no effect
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= '0;
         out_ff        <= '0;
         hiz_ff        <= '0;
         level_ff      <= '0;
         pull_en_ff    <= '0;
         pull_up_ff    <= '0;
         mask_ff       <= '0;
         status_ff     <= '0;
         sampled_ff    <= '0;
         reset_done_ff <= 1'b1;
      end else if (advance) begin
         dir_ff        <= dir_in;
         out_ff        <= out_in;
         hiz_ff        <= hiz_in;
         level_ff      <= level_in;
         pull_en_ff    <= pull_en_in;
         pull_up_ff    <= pull_up_in;
         mask_ff       <= mask_in;
         status_ff     <= status_in;
         sampled_ff    <= sampled_in;
         reset_done_ff <= reset_done_in;
      end
   end

   // ------------------------------------------------------------------
   // Pad outputs from post-update state, into the result register
   // ------------------------------------------------------------------
   pads_type         drv_en;
   gpx_pkg::rsp_type rsp_in;
   gpx_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // driven when output and either push-pull or open-drain pulling low
   assign drv_en = dir_in & (~hiz_in | ~out_in);

   always_comb begin
      rsp_in.read_data    = rd_byte;
      rsp_in.irq_n        = (status_in == '0);
      rsp_in.drive_enable = gpx_pkg::byte_type'(drv_en);
      rsp_in.drive_value  = gpx_pkg::byte_type'(out_in & drv_en);
      rsp_in.pull_up_on   = gpx_pkg::byte_type'(pull_en_in & pull_up_in);
      rsp_in.pull_down_on = gpx_pkg::byte_type'(pull_en_in & ~pull_up_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_irq_tracks_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.irq_n == (status_ff == '0)))
      else $error("irq_n disagrees with status register");

   a_status_clear_on_read: assert property (@(posedge clock) disable iff (reset)
      (advance && in_beat_ff.cmd == gpx_pkg::CMD_READ
       && in_beat_ff.reg_addr == gpx_pkg::ADDR_STATUS) |=> (status_ff == '0))
      else $error("status not cleared by read");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted beat lost from input stage");

   a_drive_within_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.drive_value & ~rsp_data.drive_enable) == '0))
      else $error("drive value on a pad that is not driven");

endmodule
